// ===== design/mfw_pkg.sv =====
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared constants, codes and types of the window median filter.
// ----------------------------------------------------------------------------
package mfw_pkg;

  localparam int PIX_W           = 8;
  localparam int DEF_WINDOW_SIZE = 3;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int CFG_W           = 16;
  localparam int IMG_W_W         = 11;
  localparam int IMG_H_W         = 16;
  localparam int RESET_WIDTH     = 1024;
  localparam int RESET_HEIGHT    = 1024;

  // request commands
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // per-result control travelling with a window
  typedef struct packed {
    logic interior;
    logic last;
  } mfw_ctl_t;

endpackage

// ===== design/mfw_median.sv =====
// ----------------------------------------------------------------------------
// mfw_median
// Two-stage rank-based median of the window plus the result register.
// Stage one registers a full pairwise compare matrix, stage two counts ranks
// and picks the element whose rank is the middle one.
// ----------------------------------------------------------------------------
module mfw_median #(
  parameter int WINDOW_SIZE = mfw_pkg::DEF_WINDOW_SIZE
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              adv,
  input  logic                                              win_valid,
  input  logic [WINDOW_SIZE*WINDOW_SIZE*mfw_pkg::PIX_W-1:0] window,
  input  mfw_pkg::mfw_ctl_t                                 win_ctl,
  output logic                                              rsp_valid,
  output logic [mfw_pkg::PIX_W-1:0]                         pixel_out,
  output logic                                              frame_last
);
  import mfw_pkg::*;

  localparam int AREA   = WINDOW_SIZE * WINDOW_SIZE;
  localparam int MID    = AREA / 2;
  localparam int RKW    = $clog2(AREA + 1);
  localparam int HALF   = WINDOW_SIZE / 2;
  localparam int CENTER = HALF * WINDOW_SIZE + HALF;

  logic [PIX_W-1:0] val [AREA];
  logic [AREA-1:0]  less_next [AREA];

  logic             cmp_valid;
  logic [AREA-1:0]  cmp_less [AREA];
  logic [PIX_W-1:0] cmp_val [AREA];
  mfw_ctl_t         cmp_ctl;

  logic [AREA-1:0]  match;
  logic [PIX_W-1:0] med;

  function automatic logic [RKW-1:0] popcount(input logic [AREA-1:0] bits);
    logic [RKW-1:0] n;
    n = '0;
    for (int k = 0; k < AREA; k++) begin
      n = n + RKW'(bits[k]);
    end
    return n;
  endfunction

  // unpack window; element j ranks below i if smaller, ties broken by index
  always_comb begin
    for (int i = 0; i < AREA; i++) begin
      val[i] = window[i*PIX_W +: PIX_W];
    end
    for (int i = 0; i < AREA; i++) begin
      for (int j = 0; j < AREA; j++) begin
        less_next[i][j] = (val[j] < val[i]) || ((val[j] == val[i]) && (j < i));
      end
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else if (adv) begin
      cmp_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmp_less <= less_next;
      cmp_val  <= val;
      cmp_ctl  <= win_ctl;
    end
  end

  // rank select
  always_comb begin
    med = '0;
    for (int i = 0; i < AREA; i++) begin
      match[i] = (popcount(cmp_less[i]) == RKW'(MID));
      med      = med | (match[i] ? cmp_val[i] : '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= cmp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out  <= cmp_ctl.interior ? med : cmp_val[CENTER];
      frame_last <= cmp_ctl.last;
    end
  end

  // interior windows hold only real pixels, so ranks form a permutation
  // and exactly one element is the median
  a_one_median: assert property (@(posedge clk) disable iff (rst)
    (cmp_valid && cmp_ctl.interior) |-> $onehot(match))
    else $error("median rank select not one-hot");

endmodule

// ===== design/median_filter_window_core.sv =====
// ----------------------------------------------------------------------------
// median_filter_window_core
// Streaming square-window median filter for raster 8-bit grayscale images.
// ----------------------------------------------------------------------------
// Takes one request per clock while req_stall is low, pixel or drain, and
// returns filtered pixels in raster order, lagging the input by half a window
// in rows and columns. The line buffer is one memory of MAX_WIDTH words, each
// holding the last WINDOW_SIZE-1 rows of one column; it is read when a request
// is taken and written back from the window stage, with a forward path
// covering the one-pixel image case. A result passes through memory read,
// window shift, compare and rank select after the request that releases it.
// Border pixels pass through unchanged. After the last pixel, send drain
// requests to flush the tail; the final result carries frame_last. Writing a
// configuration register restarts the image. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module median_filter_window_core #(
  parameter int WINDOW_SIZE = mfw_pkg::DEF_WINDOW_SIZE,
  parameter int MAX_WIDTH   = mfw_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  mfw_pkg::reg_idx_t           cfg_index,
  input  logic [mfw_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        command,
  input  logic [mfw_pkg::PIX_W-1:0]   pixel_in,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [mfw_pkg::PIX_W-1:0]   pixel_out,
  output logic                        frame_last
);
  import mfw_pkg::*;

  localparam int HALF  = WINDOW_SIZE / 2;
  localparam int LINES = WINDOW_SIZE - 1;
  localparam int AREA  = WINDOW_SIZE * WINDOW_SIZE;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CXW   = WW + 2;
  localparam int RW    = IMG_H_W + 1;
  localparam int OXW   = IMG_H_W + 2;
  localparam int LW    = $clog2(HALF * MAX_WIDTH + HALF + 1);
  localparam int MW    = LINES * PIX_W;

  // configuration
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;
  logic [WW-1:0]      w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [LW-1:0]      lag;

  // position counters
  logic [CW-1:0]      in_column, in_column_next;
  logic [RW-1:0]      in_row, in_row_next;
  logic [CW-1:0]      out_column, out_column_next;
  logic [IMG_H_W-1:0] out_row, out_row_next;
  logic [LW-1:0]      push_count, push_count_next;

  // request decode
  logic adv, accept, active, push, emit, interior, last;
  logic [PIX_W-1:0] push_pix;

  // line buffer
  logic [MW-1:0] row_store [MAX_WIDTH];
  logic [MW-1:0] rd_q;
  logic [MW-1:0] wr_data;
  logic [MW-1:0] line_old;
  logic [MW-1:0] fwd_data;
  logic          fwd_hit;
  logic          wr_en;

  // window stage
  logic             s1_valid;
  logic             s1_emit;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_pix;
  mfw_ctl_t         s1_ctl;
  logic             s2_valid;
  mfw_ctl_t         s2_ctl;
  logic [PIX_W-1:0] column [WINDOW_SIZE];
  logic [PIX_W-1:0] win [WINDOW_SIZE][WINDOW_SIZE];
  logic [AREA*PIX_W-1:0] win_flat;

  // effective sizes
  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;
    lag   = LW'(HALF) * LW'(w_eff) + LW'(HALF);
  end

  // handshake: whole pipe moves unless a held result is stalled
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;
  assign accept    = req_valid && adv;

  // request decode and counter next values
  always_comb begin
    active   = in_row < RW'(h_eff);
    push     = !active || (command == CMD_PIXEL);
    push_pix = active ? pixel_in : '0;
    emit     = push && (push_count == lag);
    interior = (out_row >= IMG_H_W'(HALF)) &&
               (OXW'(out_row) + OXW'(HALF) < OXW'(h_eff)) &&
               (out_column >= CW'(HALF)) &&
               (CXW'(out_column) + CXW'(HALF) < CXW'(w_eff));
    last     = (OXW'(out_row) + OXW'(1) == OXW'(h_eff)) &&
               (CXW'(out_column) + CXW'(1) == CXW'(w_eff));

    in_column_next  = in_column;
    in_row_next     = in_row;
    push_count_next = (push_count == lag) ? push_count : push_count + LW'(1);
    if (CXW'(in_column) + CXW'(1) == CXW'(w_eff)) begin
      in_column_next = '0;
      in_row_next    = in_row + RW'(1);
    end else begin
      in_column_next = in_column + CW'(1);
    end

    out_column_next = out_column;
    out_row_next    = out_row;
    if (CXW'(out_column) + CXW'(1) == CXW'(w_eff)) begin
      out_column_next = '0;
      out_row_next    = out_row + IMG_H_W'(1);
    end else begin
      out_column_next = out_column + CW'(1);
    end
  end

  // configuration registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMG_W_W'(RESET_WIDTH);
      image_height <= IMG_H_W'(RESET_HEIGHT);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      push_count   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_W-1:0];
        default:          image_width  <= image_width;
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      push_count <= '0;
    end else if (accept && push) begin
      if (emit && last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        push_count <= '0;
      end else begin
        in_column  <= in_column_next;
        in_row     <= in_row_next;
        push_count <= push_count_next;
        if (emit) begin
          out_column <= out_column_next;
          out_row    <= out_row_next;
        end
      end
    end
  end

  // request stage into window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit         <= emit;
      s1_col          <= in_column;
      s1_pix          <= push_pix;
      s1_ctl.interior <= interior;
      s1_ctl.last     <= last;
    end
  end

  // column assembly: old lines from memory or forward, newest pixel at bottom
  assign line_old = fwd_hit ? fwd_data : rd_q;
  assign wr_en    = adv && s1_valid;

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      column[k] = line_old[k*PIX_W +: PIX_W];
    end
    column[LINES] = s1_pix;
    for (int k = 0; k < LINES; k++) begin
      wr_data[k*PIX_W +: PIX_W] = column[k+1];
    end
  end

  // line buffer: read on request, write back from the window stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q     <= row_store[in_column];
      fwd_hit  <= wr_en && (s1_col == in_column);
      fwd_data <= wr_data;
    end
    if (wr_en) begin
      row_store[s1_col] <= wr_data;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < WINDOW_SIZE; r++) begin
        for (int c = 0; c < WINDOW_SIZE - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][WINDOW_SIZE-1] <= column[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_comb begin
    for (int r = 0; r < WINDOW_SIZE; r++) begin
      for (int c = 0; c < WINDOW_SIZE; c++) begin
        win_flat[(r*WINDOW_SIZE+c)*PIX_W +: PIX_W] = win[r][c];
      end
    end
  end

  // median and result register
  mfw_median #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_median (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .win_valid  (s2_valid),
    .window     (win_flat),
    .win_ctl    (s2_ctl),
    .rsp_valid  (rsp_valid),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  // a result is released only once the window lag has been filled
  a_emit_after_lag: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |-> (push_count == lag))
    else $error("result released before window lag filled");

  // column counter stays inside the row
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    CXW'(in_column) < CXW'(w_eff))
    else $error("input column beyond image width");

  // output row never passes the image height
  a_out_row_range: assert property (@(posedge clk) disable iff (rst)
    out_row < h_eff)
    else $error("output row beyond image height");

  // a configuration write restarts the image
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (push_count == '0) && (in_row == '0) && (out_row == '0))
    else $error("configuration write did not restart counters");

endmodule
